/* hdl/hbsd_pkg.sv */
// Package with the shared types, sizes and helpers of the Huffman tree-walk decoder.
package hbsd_pkg;

  // Node table geometry.
  localparam int NODE_COUNT = 512;
  localparam int IDX_W      = $clog2(NODE_COUNT);

  // Fixed field widths of the words on the channels.
  localparam int FIELD_IDX_W = 9;
  localparam int SYM_W       = 8;
  localparam int CNT_W       = 32;
  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_CNT_W   = 4;

  // Input word kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_CODE = 1'b1;

  // One node table entry.
  typedef struct packed {
    logic                   leaf;
    logic [SYM_W-1:0]       sym;
    logic [FIELD_IDX_W-1:0] left;
    logic [FIELD_IDX_W-1:0] right;
  } node_t;

  // Decoder sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // True when an entry index lies inside the node table.
  function automatic logic in_table(logic [FIELD_IDX_W-1:0] idx);
    return 32'(idx) < 32'(NODE_COUNT);
  endfunction

  // Table address of an entry index.
  function automatic logic [IDX_W-1:0] to_addr(logic [FIELD_IDX_W-1:0] idx);
    return IDX_W'(idx);
  endfunction

endpackage

/* hdl/hbsd_in_if.sv */
// Input channel interface: node loads and compressed code bytes.
interface hbsd_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [hbsd_pkg::FIELD_IDX_W-1:0]    node_index;
  logic                                node_is_leaf;
  logic [hbsd_pkg::SYM_W-1:0]          node_symbol;
  logic [hbsd_pkg::FIELD_IDX_W-1:0]    node_left;
  logic [hbsd_pkg::FIELD_IDX_W-1:0]    node_right;
  logic [hbsd_pkg::SYM_W-1:0]          code_byte;

  modport source (
    output valid, kind, node_index, node_is_leaf, node_symbol, node_left, node_right,
           code_byte,
    input  ready
  );

  modport sink (
    input  valid, kind, node_index, node_is_leaf, node_symbol, node_left, node_right,
           code_byte,
    output ready
  );
endinterface

/* hdl/hbsd_out_if.sv */
// Output channel interface: decoded symbols.
interface hbsd_out_if;
  logic                       valid;
  logic                       ready;
  logic [hbsd_pkg::SYM_W-1:0] symbol;
  logic                       last_of_byte;
  logic                       finished;

  modport source (
    output valid, symbol, last_of_byte, finished,
    input  ready
  );

  modport sink (
    input  valid, symbol, last_of_byte, finished,
    output ready
  );
endinterface

/* hdl/huffman_bit_serial_decoder_unit.sv */
// Top level of the Huffman tree-walk decoder with its node table memory.
//
// The code tree sits in a node table memory of NODE_COUNT entries with one
// synchronous read port; a load word writes one entry.
// A code byte walks the tree one bit per cycle unless the output stalls:
// each bit issues one read of the child entry, and the returned entry is
// checked for a leaf in the same cycle that the next bit's read goes out, so
// the dependent chain through the table read port sets the pace. A code
// byte holds the input off after it is taken while it makes eight bit reads,
// resolves the last read and releases the final symbol of the byte, so a new
// code byte is not taken until the last one is through; the hold is shorter
// when the symbol total is reached early and longer while the output stalls.
// The newest symbol is held back one step so that last_of_byte can be
// marked on it; the output register lets the next word be accepted while a
// symbol waits.
module huffman_bit_serial_decoder_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [hbsd_pkg::CNT_W-1:0]  cfg_write_data,
  hbsd_in_if.sink                     in_ch,
  hbsd_out_if.source                  out_ch
);

  // Node table memory.
  hbsd_pkg::node_t mem [hbsd_pkg::NODE_COUNT];
  hbsd_pkg::node_t mem_rd;
  logic            mem_we;
  logic [hbsd_pkg::IDX_W-1:0] mem_waddr;
  hbsd_pkg::node_t load_ent;
  logic            rd_en;
  logic [hbsd_pkg::IDX_W-1:0] rd_addr;

  // Control registers.
  hbsd_pkg::state_t state, state_next;
  logic [hbsd_pkg::BIT_CNT_W-1:0] bit_cnt, bit_cnt_next;
  logic rd_busy, rd_busy_next;
  logic [hbsd_pkg::CNT_W-1:0] count, count_next;
  logic [hbsd_pkg::CNT_W-1:0] symbol_total;
  logic [hbsd_pkg::IDX_W-1:0] cur_idx, cur_idx_next;
  logic pend_valid, pend_valid_next;
  logic out_valid, out_valid_next;

  // Payload registers.
  hbsd_pkg::node_t cur_q, cur_next;
  hbsd_pkg::node_t root_q, root_next;
  logic [hbsd_pkg::SYM_W-1:0] code_q, code_next;
  logic [hbsd_pkg::IDX_W-1:0] rd_idx, rd_idx_next;
  logic [hbsd_pkg::SYM_W-1:0] pend_sym, pend_sym_next;
  logic pend_fin, pend_fin_next;
  logic [hbsd_pkg::SYM_W-1:0] out_sym, out_sym_next;
  logic out_last, out_last_next;
  logic out_fin, out_fin_next;

  // Walk helpers.
  hbsd_pkg::node_t ent;
  logic [hbsd_pkg::FIELD_IDX_W-1:0] child;
  logic out_free;
  logic stall;
  logic stop;
  logic reach_total;

  assign load_ent = '{leaf: in_ch.node_is_leaf, sym: in_ch.node_symbol,
                      left: in_ch.node_left, right: in_ch.node_right};
  assign mem_waddr = hbsd_pkg::to_addr(in_ch.node_index);
  assign out_free = !out_valid || out_ch.ready;
  assign reach_total = (count + 32'd1) == symbol_total;

  assign in_ch.ready         = (state == hbsd_pkg::ST_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.symbol       = out_sym;
  assign out_ch.last_of_byte = out_last;
  assign out_ch.finished     = out_fin;

  // Table write port and registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= load_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_rd <= mem[rd_addr];
    end
  end

  // Next state, table access and result handling.
  always_comb begin
    state_next      = state;
    bit_cnt_next    = bit_cnt;
    rd_busy_next    = rd_busy;
    count_next      = count;
    cur_idx_next    = cur_idx;
    pend_valid_next = pend_valid;
    out_valid_next  = out_valid && !out_ch.ready;
    cur_next        = cur_q;
    root_next       = root_q;
    code_next       = code_q;
    rd_idx_next     = rd_idx;
    pend_sym_next   = pend_sym;
    pend_fin_next   = pend_fin;
    out_sym_next    = out_sym;
    out_last_next   = out_last;
    out_fin_next    = out_fin;
    mem_we          = 1'b0;
    rd_en           = 1'b0;
    ent             = cur_q;
    child           = '0;
    stall           = 1'b0;
    stop            = 1'b0;

    unique case (state)
      hbsd_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.kind == hbsd_pkg::KIND_LOAD) begin
            // Loads go to the table; the shadow copies of the root and the
            // current entry follow so the walk never reads stale children.
            if (hbsd_pkg::in_table(in_ch.node_index)) begin
              mem_we = 1'b1;
              if (mem_waddr == '0) begin
                root_next = load_ent;
              end
              if (mem_waddr == cur_idx) begin
                cur_next = load_ent;
              end
            end
          end else if (count >= symbol_total) begin
            // Decoding is over: the byte is dropped and the walk rests at the root.
            cur_idx_next = '0;
            cur_next     = root_q;
          end else begin
            code_next    = in_ch.code_byte;
            bit_cnt_next = '0;
            rd_busy_next = 1'b0;
            state_next   = hbsd_pkg::ST_WALK;
          end
        end
      end

      hbsd_pkg::ST_WALK: begin
        // Resolve the entry read for the previous bit.
        if (rd_busy) begin
          if (mem_rd.leaf) begin
            if (pend_valid && !out_free) begin
              stall = 1'b1;
            end else begin
              if (pend_valid) begin
                out_valid_next = 1'b1;
                out_sym_next   = pend_sym;
                out_last_next  = 1'b0;
                out_fin_next   = pend_fin;
              end
              pend_valid_next = 1'b1;
              pend_sym_next   = mem_rd.sym;
              pend_fin_next   = reach_total;
              count_next      = count + 32'd1;
              stop            = reach_total;
              ent             = root_q;
              cur_idx_next    = '0;
            end
          end else begin
            ent          = mem_rd;
            cur_idx_next = rd_idx;
          end
        end

        // Issue the read for the next code bit.
        if (!stall) begin
          cur_next     = ent;
          rd_busy_next = 1'b0;
          if (stop || (32'(bit_cnt) == hbsd_pkg::BITS_PER_BYTE)) begin
            state_next = hbsd_pkg::ST_FLUSH;
          end else begin
            child        = code_q[hbsd_pkg::SYM_W-1] ? ent.right : ent.left;
            code_next    = code_q << 1;
            bit_cnt_next = bit_cnt + 1'b1;
            if (hbsd_pkg::in_table(child)) begin
              rd_en        = 1'b1;
              rd_busy_next = 1'b1;
              rd_idx_next  = hbsd_pkg::to_addr(child);
            end else begin
              cur_idx_next = '0;
              cur_next     = root_q;
            end
          end
        end
      end

      hbsd_pkg::ST_FLUSH: begin
        // Release the held symbol as the last one of the byte.
        if (!pend_valid) begin
          state_next = hbsd_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          out_sym_next    = pend_sym;
          out_last_next   = 1'b1;
          out_fin_next    = pend_fin;
          pend_valid_next = 1'b0;
          state_next      = hbsd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = hbsd_pkg::ST_IDLE;
      end
    endcase
  end

  assign rd_addr = hbsd_pkg::to_addr(child);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hbsd_pkg::ST_IDLE;
      bit_cnt    <= '0;
      rd_busy    <= 1'b0;
      count      <= '0;
      cur_idx    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      bit_cnt    <= bit_cnt_next;
      rd_busy    <= rd_busy_next;
      count      <= count_next;
      cur_idx    <= cur_idx_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // Symbol total register.
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_total <= '0;
    end else if (cfg_write_en) begin
      symbol_total <= cfg_write_data;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    cur_q    <= cur_next;
    root_q   <= root_next;
    code_q   <= code_next;
    rd_idx   <= rd_idx_next;
    pend_sym <= pend_sym_next;
    pend_fin <= pend_fin_next;
    out_sym  <= out_sym_next;
    out_last <= out_last_next;
    out_fin  <= out_fin_next;
  end

endmodule

/* hdl/hbsd_checker.sv */
// Port-level assertions for the Huffman tree-walk decoder, bound to its top level.
module hbsd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_kind,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [hbsd_pkg::SYM_W-1:0] out_symbol,
  input logic                       out_last,
  input logic                       out_finished
);

  // A stalled output word holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) &&
      $stable(out_last) && $stable(out_finished))
    else $error("output word changed while stalled");

  // The symbol that reaches the total ends its byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_finished |-> out_last)
    else $error("finished symbol not marked last of byte");

  // A load leaves the decoder in its idle state, so it is ready again right after it.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_kind == hbsd_pkg::KIND_LOAD) |=> in_ready)
    else $error("decoder busy after a node load");

  // Nothing follows the finished symbol on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_finished |=> !out_valid)
    else $error("symbol emitted right after the finished symbol");

endmodule

bind huffman_bit_serial_decoder_unit hbsd_checker u_hbsd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_kind      (in_ch.kind),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_symbol   (out_ch.symbol),
  .out_last     (out_ch.last_of_byte),
  .out_finished (out_ch.finished)
);
